### rtl/core/imu_frame_sync_extractor_core_assert.svh
// assertion macros for the imu frame sync extractor checker
// expects clk_i and rst_ni in the scope of each use
`ifndef IMU_FRAME_SYNC_EXTRACTOR_CORE_ASSERT_SVH
`define IMU_FRAME_SYNC_EXTRACTOR_CORE_ASSERT_SVH

// sampled on the rising clock edge, off while reset is asserted
`define IFSE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// sampled on the rising clock edge, active during reset too
`define IFSE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/imu_fse_pkg.sv
// shared constants, tables and types of the imu frame sync extractor
// no dependencies
`timescale 1ns / 1ps

package imu_fse_pkg;

  localparam int FRAME_LEN = 127;
  localparam int OFF_W     = $clog2(FRAME_LEN);
  localparam int GRP_CNT   = 8;
  localparam int GRP_W     = $clog2(GRP_CNT);
  localparam int QIDX_W    = 5;

  localparam logic [7:0] SYNC0 = 8'h59;
  localparam logic [7:0] SYNC1 = 8'h49;
  localparam logic [7:0] SYNC2 = 8'h53;

  localparam logic [QIDX_W-1:0] QIDX_TS  = 5'd0;
  localparam logic [QIDX_W-1:0] QIDX_MAX = 5'd26;

  localparam logic [OFF_W-1:0] SKIP_LEN = OFF_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [OFF_W-1:0] rd_off;
  } win_req_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       full;
  } win_rsp_t;

  function automatic logic [7:0] grp_tag(input logic [GRP_W-1:0] g);
    logic [7:0] r;
    case (g)
      3'd0:    r = 8'h10;
      3'd1:    r = 8'h11;
      3'd2:    r = 8'h12;
      3'd3:    r = 8'h20;
      3'd4:    r = 8'h30;
      3'd5:    r = 8'h40;
      3'd6:    r = 8'h41;
      default: r = 8'h42;
    endcase
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] grp_pos(input logic [GRP_W-1:0] g);
    logic [OFF_W-1:0] r;
    case (g)
      3'd0:    r = 7'd6;
      3'd1:    r = 7'd20;
      3'd2:    r = 7'd34;
      3'd3:    r = 7'd48;
      3'd4:    r = 7'd62;
      3'd5:    r = 7'd76;
      3'd6:    r = 7'd90;
      default: r = 7'd108;
    endcase
    return r;
  endfunction

  function automatic logic [QIDX_W-1:0] grp_first(input logic [GRP_W-1:0] g);
    logic [QIDX_W-1:0] r;
    case (g)
      3'd0:    r = 5'd1;
      3'd1:    r = 5'd4;
      3'd2:    r = 5'd7;
      3'd3:    r = 5'd10;
      3'd4:    r = 5'd13;
      3'd5:    r = 5'd16;
      3'd6:    r = 5'd19;
      default: r = 5'd23;
    endcase
    return r;
  endfunction

  // index of the final word of a group
  function automatic logic [1:0] grp_wlast(input logic [GRP_W-1:0] g);
    logic [1:0] r;
    case (g)
      3'd6, 3'd7: r = 2'd3;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/imu_fse_if.sv
// valid/ready channel interfaces for serial bytes and extracted results
// depends on imu_fse_pkg
`timescale 1ns / 1ps

interface imu_fse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fse_out_if;
  logic                              valid;
  logic                              ready;
  logic [imu_fse_pkg::QIDX_W-1:0]    quantity_index;
  logic signed [31:0]                raw_value;
  logic                              last_of_frame;

  modport source (output valid, output quantity_index, output raw_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input quantity_index, input raw_value,
                  input last_of_frame, output ready);
endinterface

### rtl/core/imu_fse_window_ram.sv
// circular byte window memory with one write and one registered read port
// reads by offset from the oldest byte; depends on imu_fse_pkg
`timescale 1ns / 1ps

module imu_fse_window_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imu_fse_pkg::win_req_t req_i,
  output imu_fse_pkg::win_rsp_t rsp_o
);

  localparam int AW = imu_fse_pkg::OFF_W;

  logic [7:0]    mem [imu_fse_pkg::FRAME_LEN];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic          filled_q, filled_d;
  logic [7:0]    rd_data_q;
  logic [AW:0]   sum;
  logic [AW-1:0] rd_addr;

  // oldest byte sits at the next write address
  always_comb begin
    sum = {1'b0, wr_ptr_q} + {1'b0, req_i.rd_off};
    if (sum >= (AW+1)'(imu_fse_pkg::FRAME_LEN)) begin
      rd_addr = AW'(sum - (AW+1)'(imu_fse_pkg::FRAME_LEN));
    end else begin
      rd_addr = sum[AW-1:0];
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    filled_d = filled_q;
    if (req_i.wr_en) begin
      if (wr_ptr_q == AW'(imu_fse_pkg::FRAME_LEN - 1)) begin
        wr_ptr_d = '0;
        filled_d = 1'b1;
      end else begin
        wr_ptr_d = wr_ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      filled_q <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_ptr_q] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rsp_o.rd_data = rd_data_q;
  assign rsp_o.full    = filled_q;

endmodule

### rtl/core/imu_frame_sync_extractor_core.sv
// top level of the imu frame sync extractor: byte window, frame test, result sequencer
// depends on imu_fse_pkg, imu_fse_if and imu_fse_window_ram
`timescale 1ns / 1ps

// Usage
// rx_i takes one serial byte per beat; res_o gives results: quantity_index,
// raw_value and last_of_frame, a frame's results in order, the last one flagged.
// The last 127 bytes live in a circular memory with a single registered read
// port, and every window test is read through it one byte per cycle.
// A window that fails a sync byte or the length check is dropped once the
// failing byte is read back; a full header check reads the sync, length,
// timestamp and tag bytes in turn, and the timestamp result is registered
// once the output register is free.
// Each data word needs four byte reads, a wait for the last read data and one
// output step; a frame holds the input through its header check and all its
// data words, longer while the receiver stalls.
// No byte is taken while a window is under test.
// Reset clears the write pointer and fill flag; no window is tested until
// 127 bytes have arrived, and such a byte is dropped in the cycle after it.
// After a frame with a quaternion delta group, the next 126 bytes are only
// shifted in. A stalled receiver holds the result in the output register and
// the sequencer waits; the next byte may be taken while the final result waits.

module imu_frame_sync_extractor_core (
  input logic            clk_i,
  input logic            rst_ni,
  imu_fse_in_if.sink     rx_i,
  imu_fse_out_if.source  res_o
);

  localparam int AW = imu_fse_pkg::OFF_W;
  localparam int GW = imu_fse_pkg::GRP_W;
  localparam int QW = imu_fse_pkg::QIDX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_TS   = 3'd2;
  localparam logic [2:0] ST_WRD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [3:0] HDR_LAST  = 4'd13;
  localparam logic [3:0] HDR_END   = 4'd14;
  localparam logic [3:0] HDR_TS_LO = 4'd4;
  localparam logic [3:0] HDR_TS_HI = 4'd5;
  localparam logic [3:0] HDR_TAG0  = 4'd6;
  localparam logic [2:0] WORD_END  = 3'd4;

  function automatic logic [AW-1:0] hdr_off(input logic [3:0] i);
    logic [AW-1:0] r;
    case (i)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd1;
      4'd2:    r = 7'd2;
      4'd3:    r = 7'd5;
      4'd4:    r = 7'd3;
      4'd5:    r = 7'd4;
      default: r = imu_fse_pkg::grp_pos(GW'(i - HDR_TAG0));
    endcase
    return r;
  endfunction

  function automatic logic has_above(input logic [7:0] m, input logic [GW-1:0] g);
    logic r;
    r = 1'b0;
    for (int i = 0; i < imu_fse_pkg::GRP_CNT; i++) begin
      if (i > int'(g) && m[i]) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [GW-1:0] next_above(input logic [7:0] m, input logic [GW-1:0] g);
    logic [GW-1:0] r;
    r = g;
    for (int i = imu_fse_pkg::GRP_CNT - 1; i >= 0; i--) begin
      if (i > int'(g) && m[i]) r = GW'(i);
    end
    return r;
  endfunction

  function automatic logic [GW-1:0] first_set(input logic [7:0] m);
    logic [GW-1:0] r;
    r = '0;
    for (int i = imu_fse_pkg::GRP_CNT - 1; i >= 0; i--) begin
      if (m[i]) r = GW'(i);
    end
    return r;
  endfunction

  imu_fse_pkg::win_req_t win_req;
  imu_fse_pkg::win_rsp_t win_rsp;

  logic [2:0]        state_q, state_d;
  logic [3:0]        hi_q, hi_d;
  logic              pend_q, pend_d;
  logic [3:0]        pidx_q, pidx_d;
  logic [AW-1:0]     skip_q, skip_d;
  logic [2:0]        kk_q, kk_d;
  logic [1:0]        wrd_q, wrd_d;
  logic [GW-1:0]     grp_q, grp_d;
  logic [7:0]        newest_q, newest_d;
  logic [15:0]       ts_q, ts_d;
  logic [7:0]        mask_q, mask_d;
  logic [31:0]       word_q, word_d;
  logic              ov_q, ov_d;
  logic [QW-1:0]     oidx_q, oidx_d;
  logic signed [31:0] oval_q, oval_d;
  logic              olast_q, olast_d;

  logic              rx_fire;
  logic              slot_free;
  logic              fail;
  logic              wlast;
  logic              more;
  logic [GW-1:0]     tag_idx;
  logic [7:0]        rd_byte;

  assign rx_i.ready = (state_q == ST_IDLE);
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign slot_free  = !ov_q || res_o.ready;
  assign rd_byte    = win_rsp.rd_data;

  always_comb begin
    state_d  = state_q;
    hi_d     = hi_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    skip_d   = skip_q;
    kk_d     = kk_q;
    wrd_d    = wrd_q;
    grp_d    = grp_q;
    newest_d = newest_q;
    ts_d     = ts_q;
    mask_d   = mask_q;
    word_d   = word_q;
    ov_d     = ov_q;
    oidx_d   = oidx_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    fail     = 1'b0;
    wlast    = 1'b0;
    more     = 1'b0;
    tag_idx  = GW'(pidx_q - HDR_TAG0);
    win_req  = '0;

    if (ov_q && res_o.ready) ov_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (rx_fire) begin
          win_req.wr_en   = 1'b1;
          win_req.wr_data = rx_i.rx_byte;
          newest_d        = rx_i.rx_byte;
          if (skip_q != '0) begin
            skip_d = skip_q - AW'(1);
          end else begin
            state_d = ST_HDR;
            hi_d    = '0;
            mask_d  = '0;
          end
        end
      end
      ST_HDR: begin
        if (!pend_q && hi_q == '0 && !win_rsp.full) begin
          state_d = ST_IDLE;
        end else begin
          if (hi_q != HDR_END) begin
            win_req.rd_en  = 1'b1;
            win_req.rd_off = hdr_off(hi_q);
            pend_d         = 1'b1;
            pidx_d         = hi_q;
            hi_d           = hi_q + 4'd1;
          end
          if (pend_q) begin
            case (pidx_q)
              4'd0:      fail = (rd_byte != imu_fse_pkg::SYNC0);
              4'd1:      fail = (rd_byte != imu_fse_pkg::SYNC1);
              4'd2:      fail = (rd_byte != imu_fse_pkg::SYNC2);
              4'd3:      fail = (rd_byte != newest_q);
              HDR_TS_LO: ts_d[7:0]  = rd_byte;
              HDR_TS_HI: ts_d[15:8] = rd_byte;
              default:   mask_d[tag_idx] = (rd_byte == imu_fse_pkg::grp_tag(tag_idx));
            endcase
            if (fail) begin
              state_d = ST_IDLE;
              pend_d  = 1'b0;
            end else if (pidx_q == HDR_LAST) begin
              state_d = ST_TS;
            end
          end
        end
      end
      ST_TS: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oidx_d  = imu_fse_pkg::QIDX_TS;
          oval_d  = {16'b0, ts_q};
          olast_d = (mask_q == '0);
          if (mask_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            grp_d   = first_set(mask_q);
            wrd_d   = '0;
            kk_d    = '0;
            state_d = ST_WRD;
          end
        end
      end
      ST_WRD: begin
        if (kk_q != WORD_END) begin
          win_req.rd_en  = 1'b1;
          win_req.rd_off = AW'(imu_fse_pkg::grp_pos(grp_q) + 7'd2
                               + {3'b000, wrd_q, 2'b00} + {5'b00000, kk_q[1:0]});
          pend_d         = 1'b1;
          pidx_d         = {2'b00, kk_q[1:0]};
          kk_d           = kk_q + 3'd1;
        end
        if (pend_q) begin
          word_d[{pidx_q[1:0], 3'b000} +: 8] = rd_byte;
          if (pidx_q[1:0] == 2'd3) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          wlast   = (wrd_q == imu_fse_pkg::grp_wlast(grp_q));
          more    = has_above(mask_q, grp_q);
          ov_d    = 1'b1;
          oidx_d  = imu_fse_pkg::grp_first(grp_q) + {3'b000, wrd_q};
          oval_d  = word_q;
          olast_d = wlast && !more;
          kk_d    = '0;
          if (!wlast) begin
            wrd_d   = wrd_q + 2'd1;
            state_d = ST_WRD;
          end else if (more) begin
            grp_d   = next_above(mask_q, grp_q);
            wrd_d   = '0;
            state_d = ST_WRD;
          end else begin
            state_d = ST_IDLE;
            if (mask_q[imu_fse_pkg::GRP_CNT-1]) skip_d = imu_fse_pkg::SKIP_LEN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hi_q    <= '0;
      pend_q  <= 1'b0;
      skip_q  <= '0;
      kk_q    <= '0;
      wrd_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
      pend_q  <= pend_d;
      skip_q  <= skip_d;
      kk_q    <= kk_d;
      wrd_q   <= wrd_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    grp_q    <= grp_d;
    newest_q <= newest_d;
    ts_q     <= ts_d;
    mask_q   <= mask_d;
    word_q   <= word_d;
    oidx_q   <= oidx_d;
    oval_q   <= oval_d;
    olast_q  <= olast_d;
  end

  imu_fse_window_ram u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (win_req),
    .rsp_o  (win_rsp)
  );

  assign res_o.valid          = ov_q;
  assign res_o.quantity_index = oidx_q;
  assign res_o.raw_value      = oval_q;
  assign res_o.last_of_frame  = olast_q;

endmodule

### rtl/core/imu_fse_checker.sv
// port level checks of the imu frame sync extractor, bound to the top level
// depends on imu_fse_pkg and imu_frame_sync_extractor_core_assert.svh
`timescale 1ns / 1ps
`include "imu_frame_sync_extractor_core_assert.svh"

module imu_fse_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [imu_fse_pkg::QIDX_W-1:0] qidx_i,
  input logic [31:0]                    raw_i,
  input logic                           last_i
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  `IFSE_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result valid during reset")

  `IFSE_ASSERT_CLK(a_result_held, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(qidx_i) && $stable(raw_i) && $stable(last_i)), "stalled result changed")

  `IFSE_ASSERT_CLK(a_frame_starts_with_ts, (out_beat && last_i) |=> (!out_valid_i || qidx_i == imu_fse_pkg::QIDX_TS), "frame does not start with timestamp")

  `IFSE_ASSERT_CLK(a_ts_zero_ext, (out_valid_i && qidx_i == imu_fse_pkg::QIDX_TS) |-> (raw_i[31:16] == 16'h0000), "timestamp not zero extended")

  `IFSE_ASSERT_CLK(a_no_result_after_byte, in_beat |=> (!$rose(out_valid_i) && (!out_valid_i || qidx_i <= imu_fse_pkg::QIDX_MAX)), "result right after a byte beat")

endmodule

bind imu_frame_sync_extractor_core imu_fse_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .qidx_i      (res_o.quantity_index),
  .raw_i       (res_o.raw_value),
  .last_i      (res_o.last_of_frame)
);

### dv/imu_fse_result_board.sv
// scoreboard for the imu frame sync extractor: byte window copy and expected results
// depends on imu_fse_pkg
`timescale 1ns / 1ps

package imu_fse_result_board_pkg;
  import imu_fse_pkg::*;

  localparam logic [7:0] TAG_ACCEL      = 8'h10;
  localparam logic [7:0] TAG_FREE_ACCEL = 8'h11;
  localparam logic [7:0] TAG_DVEL       = 8'h12;
  localparam logic [7:0] TAG_GYRO       = 8'h20;
  localparam logic [7:0] TAG_MAG        = 8'h30;
  localparam logic [7:0] TAG_EULER      = 8'h40;
  localparam logic [7:0] TAG_QUAT       = 8'h41;
  localparam logic [7:0] TAG_DQUAT      = 8'h42;

  localparam logic [7:0] GROUP_TAG [GRP_CNT] = '{
    TAG_ACCEL, TAG_FREE_ACCEL, TAG_DVEL, TAG_GYRO, TAG_MAG, TAG_EULER, TAG_QUAT, TAG_DQUAT
  };
  localparam int GROUP_POS [GRP_CNT]   = '{6, 20, 34, 48, 62, 76, 90, 108};
  localparam int GROUP_WORDS [GRP_CNT] = '{3, 3, 3, 3, 3, 3, 4, 4};
  localparam logic [QIDX_W-1:0] GROUP_FIRST [GRP_CNT] = '{
    5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd23
  };

  typedef struct packed {
    logic [QIDX_W-1:0] quantity_index;
    logic [31:0]       raw_value;
    logic              last_of_frame;
  } quantity_t;

  class frame_result_board;
    logic [7:0]  window_bytes [FRAME_LEN];
    int unsigned bytes_to_skip;
    quantity_t   pending_quantities [$];
    int unsigned mismatches;

    function new();
      foreach (window_bytes[i]) window_bytes[i] = 8'h00;
      bytes_to_skip = 0;
      mismatches    = 0;
    endfunction

    function int unsigned pending_count();
      return pending_quantities.size();
    endfunction

    function logic [31:0] word_at(int pos);
      return {window_bytes[pos+3], window_bytes[pos+2], window_bytes[pos+1], window_bytes[pos]};
    endfunction

    // shift one byte in and queue whatever the new window yields
    function void take_byte(logic [7:0] rx_byte);
      quantity_t frame_out [$];
      quantity_t q;
      bit        dquat_seen;
      dquat_seen = 1'b0;
      for (int i = 0; i < FRAME_LEN - 1; i++) window_bytes[i] = window_bytes[i+1];
      window_bytes[FRAME_LEN-1] = rx_byte;
      if (bytes_to_skip != 0) begin
        bytes_to_skip--;
        return;
      end
      if (window_bytes[0] != SYNC0 || window_bytes[1] != SYNC1 || window_bytes[2] != SYNC2 ||
          window_bytes[5] != window_bytes[FRAME_LEN-1])
        return;
      q.quantity_index = QIDX_TS;
      q.raw_value      = {16'h0000, window_bytes[4], window_bytes[3]};
      q.last_of_frame  = 1'b0;
      frame_out.push_back(q);
      for (int g = 0; g < GRP_CNT; g++) begin
        if (window_bytes[GROUP_POS[g]] == GROUP_TAG[g]) begin
          for (int w = 0; w < GROUP_WORDS[g]; w++) begin
            q.quantity_index = GROUP_FIRST[g] + QIDX_W'(w);
            q.raw_value      = word_at(GROUP_POS[g] + 2 + 4 * w);
            frame_out.push_back(q);
          end
          if (g == GRP_CNT - 1) dquat_seen = 1'b1;
        end
      end
      frame_out[frame_out.size()-1].last_of_frame = 1'b1;
      foreach (frame_out[i]) pending_quantities.push_back(frame_out[i]);
      if (dquat_seen) bytes_to_skip = FRAME_LEN - 1;
    endfunction

    function void check_result(logic [QIDX_W-1:0] quantity_index, logic [31:0] raw_value,
                               logic last_of_frame);
      quantity_t exp_q;
      if (pending_quantities.size() == 0) begin
        $display("%0t unexpected result: index %0d value %h last %0b", $time,
                 quantity_index, raw_value, last_of_frame);
        mismatches++;
        return;
      end
      exp_q = pending_quantities.pop_front();
      if (quantity_index != exp_q.quantity_index) begin
        $display("%0t quantity_index mismatch: expected %0d actual %0d", $time,
                 exp_q.quantity_index, quantity_index);
        mismatches++;
      end
      if (raw_value != exp_q.raw_value) begin
        $display("%0t raw_value mismatch at index %0d: expected %h actual %h", $time,
                 exp_q.quantity_index, exp_q.raw_value, raw_value);
        mismatches++;
      end
      if (last_of_frame != exp_q.last_of_frame) begin
        $display("%0t last_of_frame mismatch at index %0d: expected %0b actual %0b", $time,
                 exp_q.quantity_index, exp_q.last_of_frame, last_of_frame);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### dv/imu_frame_sync_extractor_core_test.sv
// testbench top of the imu frame sync extractor core: directed frames, fragments and noise
// depends on imu_fse_pkg, imu_fse_if, imu_fse_result_board_pkg and the core
`timescale 1ns / 1ps

module imu_frame_sync_extractor_core_test;
  import imu_fse_pkg::*;
  import imu_fse_result_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic clk_i;
  logic rst_ni;

  imu_fse_in_if  rx_if ();
  imu_fse_out_if res_if ();

  imu_frame_sync_extractor_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  frame_result_board board = new();

  logic [7:0]  frame_buf [FRAME_LEN];
  int unsigned burst_left;
  int unsigned bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 16);
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    board.take_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  // lay out a frame in frame_buf; tag_mask bit g selects whether group g carries its tag
  task automatic build_frame(input logic [7:0] tag_mask, input logic [15:0] ts,
                             input logic [7:0] len, input bit extreme);
    logic [31:0] word;
    int          pos;
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
    frame_buf[0] = SYNC0;
    frame_buf[1] = SYNC1;
    frame_buf[2] = SYNC2;
    frame_buf[3] = ts[7:0];
    frame_buf[4] = ts[15:8];
    frame_buf[5] = len;
    frame_buf[FRAME_LEN-1] = len;
    for (int g = 0; g < GRP_CNT; g++) begin
      pos = GROUP_POS[g];
      frame_buf[pos] = tag_mask[g] ? GROUP_TAG[g] : GROUP_TAG[g] ^ 8'($urandom_range(1, 255));
      if (extreme) begin
        for (int w = 0; w < GROUP_WORDS[g]; w++) begin
          case ($urandom_range(0, 4))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'h0000_0000;
            3:       word = 32'hFFFF_FFFF;
            default: word = 32'h0000_0001;
          endcase
          for (int k = 0; k < 4; k++) frame_buf[pos+2+4*w+k] = word[8*k +: 8];
        end
      end
    end
  endtask

  task automatic send_frame(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(frame_buf[i]);
  endtask

  task automatic send_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(SYNC0);
        send_byte(SYNC1);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver ready pattern, switching mode every so often
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned run_left;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        2: res_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            res_if.ready <= 1'b1;
            run_left = $urandom_range(0, 12);
          end else begin
            res_if.ready <= 1'b0;
            run_left--;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_result(res_if.quantity_index, res_if.raw_value, res_if.last_of_frame);
  end

  initial begin
    longint unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [7:0] len_probe;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    burst_left = 0;
    bytes_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // partial frame while the window is still filling
    build_frame(8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_frame(30);
    // all groups at extreme values, then a frame tested right after the skip
    build_frame(8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_frame(FRAME_LEN);
    build_frame(8'h35, 16'h8001, 8'h5A, 1'b1);
    send_frame(FRAME_LEN);
    send_noise(4);
    // sync and length mismatches, tested while the next frame shifts in
    build_frame(8'h00, 16'h0000, 8'h00, 1'b0);
    len_probe = frame_buf[FRAME_LEN-7] ^ 8'h01;
    send_byte(SYNC0);
    send_byte(8'h7E);
    send_byte(SYNC0);
    send_byte(SYNC1);
    send_byte(8'h7E);
    send_byte(SYNC0);
    send_byte(SYNC1);
    send_byte(SYNC2);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(len_probe);
    // timestamp only
    send_frame(FRAME_LEN);
    rx_if.valid <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### imu_frame_sync_extractor_core.f
+incdir+rtl/core
rtl/core/imu_fse_pkg.sv
rtl/core/imu_fse_if.sv
rtl/core/imu_fse_window_ram.sv
rtl/core/imu_frame_sync_extractor_core.sv
rtl/core/imu_fse_checker.sv
dv/imu_fse_result_board.sv
dv/imu_frame_sync_extractor_core_test.sv
